// ===== rtl/xtea_seed_key_transform_macros.svh =====
// ---------------------------------------------------------------------------
// xtea seed key transform assertion macros
// shared concurrent assertion forms, clocked on clk with rst_n as disable
// ---------------------------------------------------------------------------
`ifndef XTEA_SEED_KEY_TRANSFORM_MACROS_SVH
`define XTEA_SEED_KEY_TRANSFORM_MACROS_SVH

// same-cycle implication
`define XST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define XST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/xst_pkg.sv =====
// ---------------------------------------------------------------------------
// xst_pkg
// types, constants and helpers shared by the seed key transform
// ---------------------------------------------------------------------------
package xst_pkg;

  localparam logic [7:0] LVL_SHIFT_XOR = 8'h01;
  localparam logic [7:0] LVL_CIPHER    = 8'h11;

  localparam logic [31:0] KEY0_RST  = 32'h4fe87269;
  localparam logic [31:0] KEY1_RST  = 32'h6bc361d8;
  localparam logic [31:0] KEY2_RST  = 32'h9b127d51;
  localparam logic [31:0] KEY3_RST  = 32'h5ba41903;
  localparam logic [31:0] DELTA_RST = 32'h8f750a1d;

  localparam int unsigned ADDR_W = 5;

  // register index, paddr[4:2]
  typedef enum logic [2:0] {
    REG_KEY0  = 3'd0,
    REG_KEY1  = 3'd1,
    REG_KEY2  = 3'd2,
    REG_KEY3  = 3'd3,
    REG_DELTA = 3'd4
  } xst_reg_t;

  typedef struct packed {
    logic [3:0][31:0] key;
    logic [31:0]      delta;
  } xst_cfg_t;

  // payload carried through the round stages
  typedef struct packed {
    logic        cipher;
    logic        status;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] sum;
  } xst_data_t;

  function automatic logic [31:0] bswap32(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

// ===== rtl/xst_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// xst_cfg_regs
// apb register file for the cipher key words and round delta
// ---------------------------------------------------------------------------
module xst_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [xst_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output xst_pkg::xst_cfg_t          cfg_o
);

  xst_pkg::xst_cfg_t cfg_r;
  xst_pkg::xst_cfg_t cfg_nxt;
  xst_pkg::xst_reg_t idx;
  logic              wr_en;

  assign idx    = xst_pkg::xst_reg_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign cfg_o  = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        xst_pkg::REG_KEY0:  cfg_nxt.key[0] = pwdata;
        xst_pkg::REG_KEY1:  cfg_nxt.key[1] = pwdata;
        xst_pkg::REG_KEY2:  cfg_nxt.key[2] = pwdata;
        xst_pkg::REG_KEY3:  cfg_nxt.key[3] = pwdata;
        xst_pkg::REG_DELTA: cfg_nxt.delta  = pwdata;
        default:            cfg_nxt        = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      xst_pkg::REG_KEY0:  prdata = cfg_r.key[0];
      xst_pkg::REG_KEY1:  prdata = cfg_r.key[1];
      xst_pkg::REG_KEY2:  prdata = cfg_r.key[2];
      xst_pkg::REG_KEY3:  prdata = cfg_r.key[3];
      xst_pkg::REG_DELTA: prdata = cfg_r.delta;
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key[0] <= xst_pkg::KEY0_RST;
      cfg_r.key[1] <= xst_pkg::KEY1_RST;
      cfg_r.key[2] <= xst_pkg::KEY2_RST;
      cfg_r.key[3] <= xst_pkg::KEY3_RST;
      cfg_r.delta  <= xst_pkg::DELTA_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/xst_y_stage.sv =====
// ---------------------------------------------------------------------------
// xst_y_stage
// first half of a round: updates y at the cipher level and advances the running sum
// ---------------------------------------------------------------------------
module xst_y_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  input  xst_pkg::xst_data_t d_i,
  input  xst_pkg::xst_cfg_t  cfg_i,
  output logic               vld_o,
  output xst_pkg::xst_data_t d_o
);

  logic               vld_r;
  xst_pkg::xst_data_t data_r;
  xst_pkg::xst_data_t data_nxt;
  logic [31:0]        mix;
  logic [31:0]        kadd;

  always_comb begin
    mix      = ((d_i.z << 4) ^ (d_i.z >> 5)) + d_i.z;
    kadd     = d_i.sum + cfg_i.key[d_i.sum[1:0]];
    data_nxt = d_i;
    // other levels keep y untouched; the sum still advances below
    if (d_i.cipher) begin
      data_nxt.y = d_i.y + (mix ^ kadd);
    end
    data_nxt.sum = d_i.sum + cfg_i.delta;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign vld_o = vld_r;
  assign d_o   = data_r;

endmodule

// ===== rtl/xst_z_stage.sv =====
// ---------------------------------------------------------------------------
// xst_z_stage
// second half of a round: updates z at the cipher level from the new y and advanced sum
// ---------------------------------------------------------------------------
module xst_z_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  input  xst_pkg::xst_data_t d_i,
  input  xst_pkg::xst_cfg_t  cfg_i,
  output logic               vld_o,
  output xst_pkg::xst_data_t d_o
);

  logic               vld_r;
  xst_pkg::xst_data_t data_r;
  xst_pkg::xst_data_t data_nxt;
  logic [31:0]        mix;
  logic [31:0]        kadd;

  always_comb begin
    mix      = ((d_i.y << 4) ^ (d_i.y >> 5)) + d_i.y;
    kadd     = d_i.sum + cfg_i.key[d_i.sum[12:11]];
    data_nxt = d_i;
    if (d_i.cipher) begin
      data_nxt.z = d_i.z + (mix ^ kadd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign vld_o = vld_r;
  assign d_o   = data_r;

endmodule

// ===== rtl/xtea_seed_key_transform.sv =====
// path: entry register, the y and z stage of each round, then the output register and out_valid strobe
// throughput: one seed per cycle, busy stays low, every round half has its own stage
// the two adds of each half round set the stage depth
// reset: synchronous active-low rst_n clears all stage valid bits and loads register defaults
// results are strobed for one cycle; the receiver cannot stall the pipeline
// ---------------------------------------------------------------------------
// xtea_seed_key_transform
// seed to key transform: shift-xor level and a fully unrolled xtea-style
// cipher level with configurable key words and delta
// ---------------------------------------------------------------------------
`include "xtea_seed_key_transform_macros.svh"

module xtea_seed_key_transform #(
  parameter int unsigned ROUNDS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // seed beat
  input  logic                       start,
  output logic                       busy,
  input  logic [31:0]                in_seed_word,
  input  logic [7:0]                 in_func,
  // key beat
  output logic                       out_valid,
  output logic [31:0]                out_key_word,
  output logic                       out_status,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [xst_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int unsigned NSTG = 2 * ROUNDS;
  localparam int unsigned LAT  = NSTG + 2;

  xst_pkg::xst_cfg_t  cfg;

  // entry stage
  logic               ent_vld_r;
  xst_pkg::xst_data_t ent_r;
  xst_pkg::xst_data_t ent_nxt;
  logic               accept;
  logic [31:0]        sx_key;

  // stage chain: index 0 is the entry register, index NSTG the last z half
  logic               stg_vld  [0:NSTG];
  xst_pkg::xst_data_t stg_data [0:NSTG];

  // output register
  logic               out_valid_r;
  logic [31:0]        out_key_word_r;
  logic               out_status_r;

  xst_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // never stalls, one seed per cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // shift-xor key is placed in z already byte-swapped so the common
  // output swap restores it; rejected levels carry z of zero
  assign sx_key = (((in_seed_word >> 4) ^ in_seed_word) << 3) ^ in_seed_word;

  always_comb begin
    ent_nxt.cipher = (in_func == xst_pkg::LVL_CIPHER);
    ent_nxt.status = (in_func != xst_pkg::LVL_CIPHER) && (in_func != xst_pkg::LVL_SHIFT_XOR);
    ent_nxt.y      = xst_pkg::bswap32(in_seed_word);
    ent_nxt.sum    = 32'd0;
    if (in_func == xst_pkg::LVL_SHIFT_XOR) begin
      ent_nxt.z = xst_pkg::bswap32(sx_key);
    end else begin
      ent_nxt.z = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
    end else begin
      ent_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign stg_vld[0]  = ent_vld_r;
  assign stg_data[0] = ent_r;

  // unrolled rounds: y half then z half, each registered
  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    xst_y_stage u_y (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (stg_vld[2*r]),
      .d_i   (stg_data[2*r]),
      .cfg_i (cfg),
      .vld_o (stg_vld[2*r+1]),
      .d_o   (stg_data[2*r+1])
    );

    xst_z_stage u_z (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (stg_vld[2*r+1]),
      .d_i   (stg_data[2*r+1]),
      .cfg_i (cfg),
      .vld_o (stg_vld[2*r+2]),
      .d_o   (stg_data[2*r+2])
    );
  end

  // output register, key swapped back to big-endian
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stg_vld[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    out_key_word_r <= xst_pkg::bswap32(stg_data[NSTG].z);
    out_status_r   <= stg_data[NSTG].status;
  end

  assign out_valid    = out_valid_r;
  assign out_key_word = out_key_word_r;
  assign out_status   = out_status_r;

  // every strobe traces back to an accepted seed beat
  `XST_ASSERT_NOW(a_out_has_seed, clk, rst_n, out_valid_r, $past(accept, LAT),
                  "key beat without seed beat")
  // rejected level always returns a zero key
  `XST_ASSERT_NOW(a_reject_zero, clk, rst_n, out_valid_r && out_status_r,
                  out_key_word_r == 32'd0, "rejected level with nonzero key")
  // status follows the level of the matching seed
  `XST_ASSERT_NOW(a_status_match, clk, rst_n, out_valid_r,
                  out_status_r == $past((in_func != xst_pkg::LVL_CIPHER) &&
                                        (in_func != xst_pkg::LVL_SHIFT_XOR), LAT),
                  "status does not match level")
  // a valid last stage always produces a strobe next cycle
  `XST_ASSERT_NEXT(a_last_to_out, clk, rst_n, stg_vld[NSTG], out_valid_r,
                   "last stage beat dropped")

endmodule

// ===== sim/xtea_seed_key_transform_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xtea_seed_key_transform_test
// self-checking bench for the seed key transform: drives seed beats at
// varying rates, programs the key words and delta between phases, and
// compares every strobed key against an in-bench model of both levels
// ---------------------------------------------------------------------------

typedef struct packed {
  logic [31:0] key_word;
  logic        status;
} key_result_t;

class key_scoreboard;
  logic [31:0] key_words [4];
  logic [31:0] delta;
  key_result_t pending_keys [$];
  int unsigned errors;
  int unsigned keys_checked;

  function new();
    errors       = 0;
    keys_checked = 0;
    reset_regs();
  endfunction

  function void reset_regs();
    key_words[0] = xst_pkg::KEY0_RST;
    key_words[1] = xst_pkg::KEY1_RST;
    key_words[2] = xst_pkg::KEY2_RST;
    key_words[3] = xst_pkg::KEY3_RST;
    delta        = xst_pkg::DELTA_RST;
  endfunction

  // slots past the delta register are ignored
  function void set_reg(logic [2:0] idx, logic [31:0] value);
    case (idx)
      xst_pkg::REG_KEY0:  key_words[0] = value;
      xst_pkg::REG_KEY1:  key_words[1] = value;
      xst_pkg::REG_KEY2:  key_words[2] = value;
      xst_pkg::REG_KEY3:  key_words[3] = value;
      xst_pkg::REG_DELTA: delta        = value;
      default: ;
    endcase
  endfunction

  function logic [31:0] reverse_bytes(logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function logic [31:0] cipher_key(logic [31:0] seed, int unsigned rounds);
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] sum;
    y   = reverse_bytes(seed);
    z   = '0;
    sum = '0;
    for (int r = 0; r < rounds; r++) begin
      y   = y + ((((z << 4) ^ (z >> 5)) + z) ^ (sum + key_words[sum[1:0]]));
      sum = sum + delta;
      z   = z + ((((y << 4) ^ (y >> 5)) + y) ^ (sum + key_words[sum[12:11]]));
    end
    return reverse_bytes(z);
  endfunction

  function void note_seed(logic [31:0] seed, logic [7:0] func, int unsigned rounds);
    key_result_t res;
    logic [31:0] mixed;
    res.status = 1'b0;
    if (func == xst_pkg::LVL_SHIFT_XOR) begin
      mixed        = (seed >> 4) ^ seed;
      res.key_word = (mixed << 3) ^ seed;
    end else if (func == xst_pkg::LVL_CIPHER) begin
      res.key_word = cipher_key(seed, rounds);
    end else begin
      res.key_word = '0;
      res.status   = 1'b1;
    end
    pending_keys.push_back(res);
  endfunction

  function void check_key(logic [31:0] key_word, logic status);
    key_result_t want;
    if (pending_keys.size() == 0) begin
      $error("key beat with no seed outstanding: key_word %h status %b", key_word, status);
      errors++;
      return;
    end
    want = pending_keys.pop_front();
    keys_checked++;
    if (key_word !== want.key_word) begin
      $error("key_word mismatch: expected %h, actual %h", want.key_word, key_word);
      errors++;
    end
    if (status !== want.status) begin
      $error("status mismatch: expected %b, actual %b", want.status, status);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return pending_keys.size();
  endfunction
endclass

module xtea_seed_key_transform_test;

  localparam int unsigned CIPHER_ROUNDS    = 64;
  localparam int unsigned PIPE_LATENCY     = 2 * CIPHER_ROUNDS + 2;
  localparam int unsigned STALL_LIMIT      = 4000;
  localparam int unsigned PHASE_COUNT      = 6;
  localparam int unsigned RANDOM_PER_PHASE = 200;
  localparam int unsigned RESET_CYCLES     = 9;
  localparam logic [2:0]  SPARE_SLOT_FIRST = 3'd5;
  localparam logic [2:0]  SPARE_SLOT_LAST  = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_seed_word = '0;
  logic [7:0]  in_func = '0;
  logic        out_valid;
  logic [31:0] out_key_word;
  logic        out_status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [xst_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  key_scoreboard book;
  int unsigned   sender_idle_pct = 0;
  int unsigned   seeds_sent = 0;
  int unsigned   settings_used = 1;
  int unsigned   quiet_cycles = 0;

  xtea_seed_key_transform #(
    .ROUNDS(CIPHER_ROUNDS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_seed_word(in_seed_word),
    .in_func     (in_func),
    .out_valid   (out_valid),
    .out_key_word(out_key_word),
    .out_status  (out_status),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 8 ns clock
  initial begin
    forever #4 clk = ~clk;
  end

  // key beats: the receiver cannot stall, so every strobe is checked at once
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      book.check_key(out_key_word, out_status);
    end
  end

  // any accepted seed beat, key beat or register write counts as progress
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog: too long without progress ends the run
  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("xtea_seed_key_transform_test: errors");
    $finish;
  end

  // one seed beat, preceded by a random idle gap on the sender side
  task automatic send_seed(input logic [31:0] seed, input logic [7:0] func);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_seed_word <= seed;
    in_func      <= func;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
    // beat taken at this edge
    book.note_seed(seed, func, CIPHER_ROUNDS);
    seeds_sent++;
  endtask

  // register write: setup phase, access phase until pready, then back to idle
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    book.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_keys(input logic [31:0] k0, input logic [31:0] k1,
                              input logic [31:0] k2, input logic [31:0] k3,
                              input logic [31:0] d);
    write_reg(xst_pkg::REG_KEY0, k0);
    write_reg(xst_pkg::REG_KEY1, k1);
    write_reg(xst_pkg::REG_KEY2, k2);
    write_reg(xst_pkg::REG_KEY3, k3);
    write_reg(xst_pkg::REG_DELTA, d);
    @(posedge clk);
    settings_used++;
  endtask

  // lower start, wait out all outstanding keys, then let the pipe settle
  task automatic drain_keys(input int unsigned settle);
    start <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // mostly the two supported levels, the rest any byte at all
  task automatic send_random_seed();
    logic [31:0] seed;
    logic [7:0]  func;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      func = xst_pkg::LVL_CIPHER;
    end else if (pick < 80) begin
      func = xst_pkg::LVL_SHIFT_XOR;
    end else begin
      func = 8'($urandom_range(255));
    end
    pick = $urandom_range(99);
    if (pick < 3) begin
      seed = '0;
    end else if (pick < 6) begin
      seed = '1;
    end else begin
      seed = $urandom;
    end
    send_seed(seed, func);
  endtask

  // corner seeds at both levels, then a spread of rejected levels
  task automatic run_directed();
    logic [31:0] corner_seeds [6];
    logic [7:0]  bad_levels [8];
    corner_seeds = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000,
                     32'h0000_0001, 32'h1234_5678, 32'ha5a5_a5a5};
    bad_levels   = '{8'h00, 8'hff, 8'h10, 8'h02, 8'h21, 8'h80, 8'h7f, 8'h12};
    foreach (corner_seeds[i]) begin
      send_seed(corner_seeds[i], xst_pkg::LVL_SHIFT_XOR);
      send_seed(corner_seeds[i], xst_pkg::LVL_CIPHER);
    end
    foreach (bad_levels[i]) begin
      send_seed($urandom, bad_levels[i]);
    end
  endtask

  initial begin : stimulus
    book = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults, back-to-back directed beats
    sender_idle_pct = 0;
    run_directed();
    drain_keys(4);

    for (int p = 1; p < PHASE_COUNT; p++) begin
      case (p)
        1: program_keys('0, '0, '0, '0, '0);
        2: program_keys('1, '1, '1, '1, '1);
        3: begin
          // writes past the last register must not disturb anything
          for (int s = SPARE_SLOT_FIRST; s <= SPARE_SLOT_LAST; s++) begin
            write_reg(s[2:0], $urandom);
          end
          program_keys($urandom, $urandom, $urandom, $urandom, $urandom);
        end
        4: program_keys('0, '1, $urandom, $urandom, 32'h9e37_79b9);
        default: program_keys($urandom, $urandom, $urandom, $urandom, $urandom);
      endcase
      // sender rates rotate through full rate, sparse and lightly gapped
      case (p % 3)
        0: sender_idle_pct = 15;
        1: sender_idle_pct = 88;
        default: sender_idle_pct = 0;
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_random_seed();
      end
      drain_keys(4);
    end

    // final settle covers a full pipe of stray strobes
    drain_keys(PIPE_LATENCY + 8);
    if (book.pending() != 0) begin
      $error("%0d keys never arrived", book.pending());
      book.errors++;
    end

    $display("covered %0d seed beats under %0d register settings, %0d keys compared",
             seeds_sent, settings_used, book.keys_checked);
    $display("sender idle rates of 0, 15 and 88 percent; %0d mismatches", book.errors);
    if (book.errors == 0) begin
      $display("xtea_seed_key_transform_test: clean");
    end else begin
      $display("xtea_seed_key_transform_test: errors");
    end
    $finish;
  end

endmodule
